// File: hdl/stack_machine_execute_unit_defines.svh
// Assertion macros used by the checker file of the stack machine execute unit.
`ifndef STACK_MACHINE_EXECUTE_UNIT_DEFINES_SVH
`define STACK_MACHINE_EXECUTE_UNIT_DEFINES_SVH
// Implication checked at every clock edge, disabled while reset is applied.
`define SMEU_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Consequent checked at the clock edge after the antecedent, disabled while reset is applied.
`define SMEU_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`endif

// File: hdl/smeu_pkg.sv
// Package with the instruction and fault codes of the stack machine execute unit.
`default_nettype none
package smeu_pkg;
  localparam int unsigned FuncW = 5;
  localparam int unsigned FaultW = 3;
  localparam logic [FuncW-1:0] F_PUSH = 5'd0, F_POP = 5'd1, F_COPY = 5'd2, F_RVAL = 5'd3,
    F_LVAL = 5'd4, F_ASSIGN = 5'd5, F_ADD = 5'd6, F_SUB = 5'd7, F_MUL = 5'd8, F_DIV = 5'd9,
    F_MOD = 5'd10, F_AND = 5'd11, F_OR = 5'd12, F_NOT = 5'd13, F_NE = 5'd14, F_LE = 5'd15,
    F_GE = 5'd16, F_LT = 5'd17, F_GT = 5'd18, F_EQ = 5'd19, F_GOFALSE = 5'd20,
    F_GOTRUE = 5'd21;
  localparam logic [FaultW-1:0] FLT_NONE = 3'd0, FLT_UNDER = 3'd1, FLT_OVER = 3'd2,
    FLT_DIVZ = 3'd3, FLT_NOTADDR = 3'd4;
  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_EXEC, ST_DIV, ST_CLEAR, ST_OUT
  } state_e;
endpackage
`default_nettype wire

// File: hdl/smeu_ram.sv
// Generic single-port RAM with registered read data.
`default_nettype none
module smeu_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

// File: hdl/stack_machine_execute_unit.sv
// Top level of the stack machine execute unit: stack, variables, sequencer and shared ALU.
// One instruction is accepted when the unit is idle. The top two stack entries live in
// registers, the rest in a stack RAM; the variables live in a variable RAM. An instruction
// passes through accept, memory read, execute and result steps. Div and mod also pass
// through the restoring divider, which forms the quotient bits one per cycle and then the
// signed result; assign also refills both cached entries from the stack RAM. After reset a
// clearing pass writes zero to every variable, one per cycle, before the first transfer.
// While a result waits for its transfer no new instruction is taken.
`default_nettype none
module stack_machine_execute_unit #(
  parameter int unsigned STACK_DEPTH = 64,
  parameter int unsigned VAR_COUNT = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [4:0]  func_i,
  input  wire logic signed [31:0] push_value_i,
  input  wire logic [7:0]  var_index_i,
  input  wire logic [15:0] branch_target_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic signed [31:0] top_value_o,
  output logic             top_is_address_o,
  output logic [6:0]       stack_depth_o,
  output logic             jump_taken_o,
  output logic [15:0]      jump_target_o,
  output logic [2:0]       fault_o
);
  import smeu_pkg::*;
  localparam int unsigned SpW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned SaW = $clog2(STACK_DEPTH);
  localparam int unsigned VaW = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;

  state_e state_q, state_d;
  logic [SpW-1:0] sp_q, sp_d;
  // t0 is the top entry, t1 the entry below; bit 32 is the address tag.
  logic [32:0] t0_q, t0_d, t1_q, t1_d;
  logic [4:0] f_q;
  logic [31:0] pv_q;
  logic [VaW-1:0] vi_q;
  logic [15:0] tgt_q;
  logic [VaW-1:0] clr_q, clr_d;
  logic [31:0] rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic [5:0] cnt_q, cnt_d;
  logic ng_q, ng_d, nr_q, nr_d;
  logic r_taken_q, r_taken_d;
  logic [2:0] r_fault_q, r_fault_d;

  // Stack RAM holds entries below the two cached ones.
  logic s_we;
  logic [SaW-1:0] s_addr;
  logic [32:0] s_wdata, s_rdata;
  logic v_we;
  logic [VaW-1:0] v_addr;
  logic [31:0] v_wdata, v_rdata;

  smeu_ram #(.Width(33), .Depth(STACK_DEPTH)) u_stack (
    .clk_i, .we_i(s_we), .addr_i(s_addr), .wdata_i(s_wdata), .rdata_o(s_rdata));
  smeu_ram #(.Width(32), .Depth(VAR_COUNT)) u_vars (
    .clk_i, .we_i(v_we), .addr_i(v_addr), .wdata_i(v_wdata), .rdata_o(v_rdata));

  logic [1:0] need;
  logic room;
  logic [2:0] pre_fault;
  always_comb begin
    need = 2'd0;
    room = 1'b0;
    case (f_q)
      F_PUSH, F_RVAL, F_LVAL: room = 1'b1;
      F_COPY: begin need = 2'd1; room = 1'b1; end
      F_POP, F_NOT, F_GOFALSE, F_GOTRUE: need = 2'd1;
      default: if (f_q inside {[F_ASSIGN:F_EQ]}) need = 2'd2;
    endcase
    if (sp_q < SpW'(need)) pre_fault = FLT_UNDER;
    else if (room && sp_q >= SpW'(STACK_DEPTH)) pre_fault = FLT_OVER;
    else if (f_q == F_ASSIGN && !t1_q[32]) pre_fault = FLT_NOTADDR;
    else if ((f_q == F_DIV || f_q == F_MOD) && t0_q[31:0] == '0) pre_fault = FLT_DIVZ;
    else pre_fault = FLT_NONE;
  end

  // Shared ALU over the two cached entries.
  logic [31:0] x, y, alu;
  logic [32:0] diff;
  logic slt, eqv;
  always_comb begin
    x = t1_q[31:0];
    y = t0_q[31:0];
    diff = {1'b0, x} - {1'b0, y};
    eqv = (x == y);
    slt = (x[31] != y[31]) ? x[31] : diff[32];
    case (f_q)
      F_ADD: alu = x + y;
      F_SUB: alu = diff[31:0];
      F_MUL: alu = x * y;
      F_AND: alu = {31'd0, (x != '0) && (y != '0)};
      F_OR:  alu = {31'd0, (x != '0) || (y != '0)};
      F_NE:  alu = {31'd0, !eqv};
      F_LE:  alu = {31'd0, slt || eqv};
      F_GE:  alu = {31'd0, !slt};
      F_LT:  alu = {31'd0, slt};
      F_GT:  alu = {31'd0, !slt && !eqv};
      default: alu = {31'd0, eqv};
    endcase
  end

  logic [32:0] dtrial;
  logic [31:0] dres;
  always_comb begin
    dtrial = {rem_q, quo_q[31]} - {1'b0, dvs_q};
    dres = (f_q == F_DIV) ? (nr_q ? -quo_q : quo_q) : (ng_q ? -rem_q : rem_q);
  end

  always_comb begin
    state_d = state_q;
    sp_d = sp_q; t0_d = t0_q; t1_d = t1_q;
    clr_d = clr_q; rem_d = rem_q; quo_d = quo_q; dvs_d = dvs_q; cnt_d = cnt_q;
    ng_d = ng_q; nr_d = nr_q; r_taken_d = r_taken_q; r_fault_d = r_fault_q;
    s_we = 1'b0; s_addr = SaW'(sp_q - SpW'(3)); s_wdata = t1_q;
    v_we = 1'b0; v_addr = vi_q; v_wdata = t0_q[31:0];
    case (state_q)
      ST_CLEAR: begin
        v_we = 1'b1; v_addr = clr_q; v_wdata = '0;
        clr_d = clr_q + 1'b1;
        if (clr_q == VaW'(VAR_COUNT - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: if (in_valid_i) state_d = ST_READ;
      ST_READ: begin
        // Address the stack entry that refills t1 after a pop.
        s_addr = SaW'(sp_q - SpW'(3));
        if (f_q == F_ASSIGN) v_addr = VaW'(t1_q[31:0] % VAR_COUNT);
        r_fault_d = pre_fault; r_taken_d = 1'b0;
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = ST_OUT;
        if (r_fault_q == FLT_NONE) begin
          case (f_q)
            F_PUSH, F_COPY, F_RVAL, F_LVAL: begin
              if (sp_q >= SpW'(2)) begin s_we = 1'b1; s_addr = SaW'(sp_q - SpW'(2)); end
              t1_d = t0_q;
              case (f_q)
                F_PUSH: t0_d = {1'b0, pv_q};
                F_RVAL: t0_d = {1'b0, v_rdata};
                F_LVAL: t0_d = {1'b1, 32'(vi_q)};
                default: t0_d = t0_q;
              endcase
              sp_d = sp_q + 1'b1;
            end
            F_POP, F_GOFALSE, F_GOTRUE: begin
              r_taken_d = (f_q != F_POP) && !t0_q[32] &&
                (t0_q[31:0] == ((f_q == F_GOFALSE) ? 32'd0 : 32'd1));
              t0_d = t1_q; t1_d = s_rdata; sp_d = sp_q - 1'b1;
            end
            F_ASSIGN: begin
              v_we = 1'b1; v_addr = VaW'(t1_q[31:0] % VAR_COUNT);
              // Two pops: refill both caches, one from the RAM read now, one next.
              t0_d = s_rdata; sp_d = sp_q - SpW'(2);
              state_d = ST_DIV; cnt_d = '1;
            end
            F_NOT: t0_d = {1'b0, 31'd0, t0_q[31:0] == '0};
            F_DIV, F_MOD: begin
              ng_d = t1_q[31]; nr_d = t1_q[31] ^ t0_q[31];
              quo_d = t1_q[31] ? -t1_q[31:0] : t1_q[31:0];
              dvs_d = t0_q[31] ? -t0_q[31:0] : t0_q[31:0];
              rem_d = '0; cnt_d = 6'd32; state_d = ST_DIV;
            end
            default: begin
              if (f_q inside {[F_ADD:F_EQ]}) begin
                t0_d = {1'b0, alu}; t1_d = s_rdata; sp_d = sp_q - 1'b1;
              end
            end
          endcase
        end
      end
      ST_DIV: begin
        if (cnt_q == '1) begin
          // Second refill after assign: fetch the entry below the new top.
          s_addr = SaW'(sp_q - SpW'(2));
          cnt_d = 6'd62;
        end else if (cnt_q == 6'd62) begin
          t1_d = s_rdata; state_d = ST_OUT;
        end else if (cnt_q != '0) begin
          if (!dtrial[32]) begin
            rem_d = dtrial[31:0]; quo_d = {quo_q[30:0], 1'b1};
          end else begin
            rem_d = {rem_q[30:0], quo_q[31]}; quo_d = {quo_q[30:0], 1'b0};
          end
          cnt_d = cnt_q - 1'b1;
        end else begin
          t0_d = {1'b0, dres}; t1_d = s_rdata; sp_d = sp_q - 1'b1; state_d = ST_OUT;
        end
      end
      ST_OUT: if (!out_stall_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR; sp_q <= '0; clr_q <= '0; cnt_q <= '0;
    end else begin
      state_q <= state_d; sp_q <= sp_d; clr_q <= clr_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t0_q <= t0_d; t1_q <= t1_d; rem_q <= rem_d; quo_q <= quo_d; dvs_q <= dvs_d;
    ng_q <= ng_d; nr_q <= nr_d; r_taken_q <= r_taken_d; r_fault_q <= r_fault_d;
    if (state_q == ST_IDLE && in_valid_i) begin
      f_q <= func_i; pv_q <= push_value_i; vi_q <= VaW'(var_index_i % VAR_COUNT);
      tgt_q <= branch_target_i;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign top_value_o = (sp_q != '0) ? t0_q[31:0] : '0;
  assign top_is_address_o = (sp_q != '0) && t0_q[32];
  assign stack_depth_o = 7'(sp_q);
  assign jump_taken_o = r_taken_q;
  assign jump_target_o = r_taken_q ? tgt_q : '0;
  assign fault_o = r_fault_q;
endmodule
`default_nettype wire

// File: hdl/smeu_checker.sv
// Port-level checker for the stack machine execute unit and its bind.
`default_nettype none
`include "stack_machine_execute_unit_defines.svh"
module smeu_checker (
  input wire logic clk_i, input wire logic rst_ni,
  input wire logic in_valid_i, input wire logic in_stall_o,
  input wire logic out_valid_o, input wire logic out_stall_i,
  input wire logic jump_taken_o, input wire logic [15:0] jump_target_o,
  input wire logic [2:0] fault_o, input wire logic [6:0] stack_depth_o
);
  import smeu_pkg::*;
  logic in_xfer, out_held, fault_seen, no_jump;
  assign in_xfer = in_valid_i && !in_stall_o;
  assign out_held = out_valid_o && out_stall_i;
  assign fault_seen = out_valid_o && (fault_o != FLT_NONE);
  assign no_jump = out_valid_o && !jump_taken_o;

  `SMEU_ASSERT(a_one_busy, clk_i, rst_ni, out_valid_o |-> in_stall_o, "result while idle")
  `SMEU_ASSERT_NEXT(a_accept_gap, clk_i, rst_ni, in_xfer, !out_valid_o, "early result")
  `SMEU_ASSERT(a_fault_nojump, clk_i, rst_ni, fault_seen |-> !jump_taken_o, "jump on fault")
  `SMEU_ASSERT(a_tgt_zero, clk_i, rst_ni, no_jump |-> jump_target_o == 16'd0, "stray target")
  `SMEU_ASSERT_NEXT(a_depth_hold, clk_i, rst_ni, out_held, $stable(stack_depth_o), "depth moved")
endmodule
bind stack_machine_execute_unit smeu_checker u_smeu_checker (.*);
`default_nettype wire
